// ===== src/tcpd_pkg.sv =====
// Shared types and constants of the two-core priority dispatcher.
// Depends on nothing.
`timescale 1ns / 1ps
package tcpd_pkg;
    localparam int PidBits = 7;
    localparam int TimeBits = 32;
    localparam int DurBits = 24;
    localparam int KindBits = 3;
    localparam int MaxProcs = 128;
    localparam int QAddrBits = 7;
    localparam int QCntBits = 8;

    localparam logic [KindBits-1:0] K_CORE_REQ = 3'd0;
    localparam logic [KindBits-1:0] K_CORE_DONE = 3'd1;
    localparam logic [KindBits-1:0] K_DISK_REQ = 3'd2;
    localparam logic [KindBits-1:0] K_DISK_DONE = 3'd3;
    localparam logic [KindBits-1:0] K_IO_REQ = 3'd4;
    localparam logic [KindBits-1:0] K_IO_DONE = 3'd5;

    localparam logic [1:0] RES_CORE0 = 2'd0;
    localparam logic [1:0] RES_CORE1 = 2'd1;
    localparam logic [1:0] RES_DISK = 2'd2;
    localparam logic [1:0] RES_NONE = 2'd3;

    typedef struct packed {
        logic [KindBits-1:0] kind;
        logic [PidBits-1:0] process_id;
        logic [TimeBits-1:0] event_time;
        logic [DurBits-1:0] duration;
    } t_event;

    typedef struct packed {
        logic granted;
        logic [1:0] resource;
        logic [PidBits-1:0] granted_pid;
        logic [TimeBits-1:0] finish_time;
        logic queued;
        logic queue_full;
        logic [1:0] busy_cores;
    } t_result;

    // Classified event handed from the front to the back.
    typedef struct packed {
        t_event ev;
        logic prio;
    } t_cls;
endpackage

// ===== src/tcpd_if.sv =====
// Valid/ready channel interfaces of the dispatcher.
// Depends on tcpd_pkg.
`timescale 1ns / 1ps
interface tcpd_ev_if;
    logic valid;
    logic ready;
    tcpd_pkg::t_event data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface tcpd_res_if;
    logic valid;
    logic ready;
    tcpd_pkg::t_result data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// ===== src/tcpd_front.sv =====
// Front part: accepts events, keeps the priority bits and classifies requests.
// Depends on tcpd_pkg.
`timescale 1ns / 1ps
module tcpd_front (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  tcpd_pkg::t_event i_ev,
    output logic o_push,
    output tcpd_pkg::t_cls o_cls,
    input  logic i_q_space
);
    logic [tcpd_pkg::MaxProcs-1:0] r_prio;
    logic w_acc;
    logic w_clr;

    assign o_ready = i_q_space;
    assign w_acc = i_valid && i_q_space;
    assign o_push = w_acc;
    assign o_cls.ev = i_ev;
    assign o_cls.prio = r_prio[i_ev.process_id];
    assign w_clr = (i_ev.kind == tcpd_pkg::K_DISK_DONE) ||
        ((i_ev.kind == tcpd_pkg::K_DISK_REQ) && (i_ev.duration == '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= '0;
        end else if (w_acc) begin
            if (w_clr) begin
                r_prio[i_ev.process_id] <= 1'b0;
            end else if (i_ev.kind == tcpd_pkg::K_IO_DONE) begin
                r_prio[i_ev.process_id] <= 1'b1;
            end
        end
    end
endmodule

// ===== src/tcpd_queue.sv =====
// Two-entry queue between the front and the back.
// Depends on tcpd_pkg.
`timescale 1ns / 1ps
module tcpd_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  tcpd_pkg::t_cls i_data,
    output logic o_space,
    output logic o_valid,
    output tcpd_pkg::t_cls o_data,
    input  logic i_pop
);
    tcpd_pkg::t_cls r_mem [2];
    logic r_wp;
    logic r_rp;
    logic [1:0] r_cnt;

    assign o_space = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end
endmodule

// ===== src/tcpd_back.sv =====
// Back part: cores, disk, wait queues in memory and result register.
// Depends on tcpd_pkg.
`timescale 1ns / 1ps
module tcpd_back (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  tcpd_pkg::t_cls i_cls,
    output logic o_pop,
    output logic o_valid,
    output tcpd_pkg::t_result o_res,
    input  logic i_ready
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;
    localparam logic [1:0] S_OUT = 2'd3;
    localparam int EntBits = tcpd_pkg::PidBits + tcpd_pkg::DurBits;
    localparam int Depth = tcpd_pkg::MaxProcs;

    logic [EntBits-1:0] r_hq [Depth];
    logic [EntBits-1:0] r_lq [Depth];
    logic [EntBits-1:0] r_dq [Depth];
    logic [EntBits-1:0] r_hd, r_ld, r_dd;

    logic [1:0] r_state;
    tcpd_pkg::t_cls r_cur;
    logic [1:0] r_busy;
    logic [tcpd_pkg::TimeBits-1:0] r_fin [2];
    logic r_disk;
    logic [tcpd_pkg::QAddrBits-1:0] r_hh, r_lh, r_dh;
    logic [tcpd_pkg::QCntBits-1:0] r_hc, r_lc, r_dc;
    tcpd_pkg::t_result r_res;

    tcpd_pkg::t_event w_ev;
    logic [tcpd_pkg::TimeBits-1:0] w_sum;
    logic [tcpd_pkg::DurBits-1:0] w_dsel;
    logic w_c;
    logic w_hpop, w_lpop, w_dpop, w_hpush, w_lpush, w_dpush;
    tcpd_pkg::t_result w_r;
    logic [1:0] w_nbusy;
    logic w_ndisk;
    logic w_setfin;

    assign w_ev = r_cur.ev;
    assign o_pop = (r_state == S_IDLE) && i_valid;
    assign o_valid = (r_state == S_OUT);
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        r_hd <= r_hq[r_hh];
        r_ld <= r_lq[r_lh];
        r_dd <= r_dq[r_dh];
    end

    always_comb begin
        w_r = '0;
        w_r.resource = tcpd_pkg::RES_NONE;
        w_hpop = 1'b0; w_lpop = 1'b0; w_dpop = 1'b0;
        w_hpush = 1'b0; w_lpush = 1'b0; w_dpush = 1'b0;
        w_nbusy = r_busy;
        w_ndisk = r_disk;
        w_setfin = 1'b0;
        w_c = 1'b0;
        w_dsel = w_ev.duration;
        if (w_ev.kind == tcpd_pkg::K_CORE_DONE) begin
            w_dsel = (r_hc != '0) ? r_hd[tcpd_pkg::DurBits-1:0]
                                 : r_ld[tcpd_pkg::DurBits-1:0];
        end else if (w_ev.kind == tcpd_pkg::K_DISK_DONE) begin
            w_dsel = r_dd[tcpd_pkg::DurBits-1:0];
        end
        w_sum = w_ev.event_time + {{(tcpd_pkg::TimeBits-tcpd_pkg::DurBits){1'b0}}, w_dsel};
        unique case (w_ev.kind)
            tcpd_pkg::K_CORE_REQ: begin
                if (!(r_busy[0] && r_busy[1])) begin
                    w_c = r_busy[0];
                    w_nbusy[w_c] = 1'b1;
                    w_setfin = 1'b1;
                    w_r.granted = 1'b1;
                    w_r.resource = {1'b0, w_c};
                    w_r.granted_pid = w_ev.process_id;
                    w_r.finish_time = w_sum;
                end else if (r_cur.prio) begin
                    if (r_hc != Depth[tcpd_pkg::QCntBits-1:0]) begin
                        w_hpush = 1'b1; w_r.queued = 1'b1;
                    end else begin
                        w_r.queue_full = 1'b1;
                    end
                end else begin
                    if (r_lc != Depth[tcpd_pkg::QCntBits-1:0]) begin
                        w_lpush = 1'b1; w_r.queued = 1'b1;
                    end else begin
                        w_r.queue_full = 1'b1;
                    end
                end
            end
            tcpd_pkg::K_CORE_DONE: begin
                w_c = (r_fin[0] != w_ev.event_time);
                if (r_hc == '0 && r_lc == '0) begin
                    w_nbusy[w_c] = 1'b0;
                end else begin
                    w_hpop = (r_hc != '0);
                    w_lpop = (r_hc == '0);
                    w_nbusy[w_c] = 1'b1;
                    w_setfin = 1'b1;
                    w_r.granted = 1'b1;
                    w_r.resource = {1'b0, w_c};
                    w_r.granted_pid = w_hpop ? r_hd[EntBits-1:tcpd_pkg::DurBits]
                                             : r_ld[EntBits-1:tcpd_pkg::DurBits];
                    w_r.finish_time = w_sum;
                end
            end
            tcpd_pkg::K_DISK_REQ: begin
                if (w_ev.duration == '0) begin
                    w_r.granted = 1'b1;
                    w_r.resource = tcpd_pkg::RES_DISK;
                    w_r.granted_pid = w_ev.process_id;
                    w_r.finish_time = w_ev.event_time;
                end else if (!r_disk) begin
                    w_ndisk = 1'b1;
                    w_r.granted = 1'b1;
                    w_r.resource = tcpd_pkg::RES_DISK;
                    w_r.granted_pid = w_ev.process_id;
                    w_r.finish_time = w_sum;
                end else if (r_dc != Depth[tcpd_pkg::QCntBits-1:0]) begin
                    w_dpush = 1'b1; w_r.queued = 1'b1;
                end else begin
                    w_r.queue_full = 1'b1;
                end
            end
            tcpd_pkg::K_DISK_DONE: begin
                if (r_dc == '0) begin
                    w_ndisk = 1'b0;
                end else begin
                    w_dpop = 1'b1;
                    w_ndisk = 1'b1;
                    w_r.granted = 1'b1;
                    w_r.resource = tcpd_pkg::RES_DISK;
                    w_r.granted_pid = r_dd[EntBits-1:tcpd_pkg::DurBits];
                    w_r.finish_time = w_sum;
                end
            end
            tcpd_pkg::K_IO_REQ: begin
                w_r.granted = 1'b1;
                w_r.resource = tcpd_pkg::RES_NONE;
                w_r.granted_pid = w_ev.process_id;
                w_r.finish_time = w_sum;
            end
            default: begin
            end
        endcase
        w_r.busy_cores = {1'b0, w_nbusy[0]} + {1'b0, w_nbusy[1]};
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EXEC) begin
            if (w_hpush) begin
                r_hq[r_hh + r_hc[tcpd_pkg::QAddrBits-1:0]] <=
                    {w_ev.process_id, w_ev.duration};
            end
            if (w_lpush) begin
                r_lq[r_lh + r_lc[tcpd_pkg::QAddrBits-1:0]] <=
                    {w_ev.process_id, w_ev.duration};
            end
            if (w_dpush) begin
                r_dq[r_dh + r_dc[tcpd_pkg::QAddrBits-1:0]] <=
                    {w_ev.process_id, w_ev.duration};
            end
            r_res <= w_r;
        end
        if (o_pop) begin
            r_cur <= i_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy <= '0;
            r_disk <= 1'b0;
            r_hh <= '0; r_lh <= '0; r_dh <= '0;
            r_hc <= '0; r_lc <= '0; r_dc <= '0;
            r_fin[0] <= '0;
            r_fin[1] <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_OUT;
                    r_busy <= w_nbusy;
                    r_disk <= w_ndisk;
                    if (w_setfin) begin
                        r_fin[w_c] <= w_sum;
                    end
                    if (w_hpop) begin
                        r_hh <= r_hh + 1'b1;
                        r_hc <= r_hc - 1'b1;
                    end
                    if (w_lpop) begin
                        r_lh <= r_lh + 1'b1;
                        r_lc <= r_lc - 1'b1;
                    end
                    if (w_dpop) begin
                        r_dh <= r_dh + 1'b1;
                        r_dc <= r_dc - 1'b1;
                    end
                    if (w_hpush) begin
                        r_hc <= r_hc + 1'b1;
                    end
                    if (w_lpush) begin
                        r_lc <= r_lc + 1'b1;
                    end
                    if (w_dpush) begin
                        r_dc <= r_dc + 1'b1;
                    end
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end
endmodule

// ===== src/two_core_priority_dispatcher.sv =====
// Top level of the two-core priority dispatcher.
// Depends on tcpd_pkg, tcpd_if, tcpd_front, tcpd_queue and tcpd_back.
//
// One event beat enters on i_ev (kind, process_id, event_time, duration) and
// gives exactly one result beat on o_res. The front keeps the per-process
// priority bits and tags each event with its priority; a two-entry queue
// decouples it from the back, which owns the core and disk state and the
// three wait queues held in memories with registered reads.
// The back handles one event at a time: it takes it from the queue, reads the
// queue heads from memory, executes, then holds the result until it is taken.
// It takes no new event from the queue until the last result has been taken.
// While the receiver stalls, the result stays put and the front goes on
// accepting until the queue is full.
// Reset clears the cores, the disk, the queue counts and all priority bits;
// no clearing pass is needed.
`timescale 1ns / 1ps
module two_core_priority_dispatcher (
    input  logic i_clk,
    input  logic i_rst_n,
    tcpd_ev_if.sink i_ev,
    tcpd_res_if.source o_res
);
    logic w_push;
    logic w_space;
    logic w_qvalid;
    logic w_pop;
    tcpd_pkg::t_cls w_cls_in;
    tcpd_pkg::t_cls w_cls_out;

    tcpd_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_ev.valid), .o_ready(i_ev.ready), .i_ev(i_ev.data),
        .o_push(w_push), .o_cls(w_cls_in), .i_q_space(w_space)
    );

    tcpd_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_data(w_cls_in), .o_space(w_space),
        .o_valid(w_qvalid), .o_data(w_cls_out), .i_pop(w_pop)
    );

    tcpd_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(w_qvalid), .i_cls(w_cls_out), .o_pop(w_pop),
        .o_valid(o_res.valid), .o_res(o_res.data), .i_ready(o_res.ready)
    );

    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qvalid) else $error("Pop from an empty queue.");
    a_busy_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.data.busy_cores != 2'd3)
        else $error("Busy core count out of range.");
    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.data.queued && o_res.data.queue_full))
        else $error("Queued and full flagged together.");
    a_nogrant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.data.granted) |-> o_res.data.resource == tcpd_pkg::RES_NONE)
        else $error("Resource given without a grant.");
endmodule
